// ===== rtl/sfq_pkg.sv =====
// Shared widths, operation codes and status codes of the searchable FIFO queue.
package sfq_pkg;

   // Field widths of the request and response transactions.
   localparam int KIND_W      = 2;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int POS_W       = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   // Operation codes carried in req_tuser.
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

   // Result status carried in rsp_tuser.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

endpackage

// ===== rtl/sfq_mem.sv =====
// Entry storage: one write port and one read port with a registered read.
module sfq_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [sfq_pkg::WORD_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [sfq_pkg::WORD_W-1:0] rd_data
);
   import sfq_pkg::*;

   logic [WORD_W-1:0] entries_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sfq_ctrl.sv =====
// Queue sequencer: head, tail and occupancy, pop and search walks, response register.
module sfq_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sfq_pkg::KIND_W-1:0]      req_kind,
   input  logic signed [sfq_pkg::WORD_W-1:0] req_value,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output sfq_pkg::status_type             rsp_status,
   output logic signed [sfq_pkg::WORD_W-1:0] rsp_popped_value,
   output logic [sfq_pkg::POS_W-1:0]       rsp_position,
   output logic                            mem_wr_en,
   output logic [AW-1:0]                   mem_wr_addr,
   output logic [sfq_pkg::WORD_W-1:0]      mem_wr_data,
   output logic                            mem_rd_en,
   output logic [AW-1:0]                   mem_rd_addr,
   input  logic [sfq_pkg::WORD_W-1:0]      mem_rd_data
);
   import sfq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HOLD,
      S_POP,
      S_SEARCH
   } state_type;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   state_type          state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      scan_addr_ff, scan_addr_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [WORD_W-1:0]  key_ff, key_in;
   status_type         pend_status_ff, pend_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]  rsp_popped_ff, rsp_popped_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic               out_free;
   logic               hit;
   logic               req_fire;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
      return (idx == LAST_ADDR) ? '0 : idx + 1'b1;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign hit        = (mem_rd_data == key_ff);

   // Next-state logic for the sequencer, the queue pointers and the response.
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      scan_addr_in   = scan_addr_ff;
      scan_in        = scan_ff;
      key_in         = key_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_popped_in  = rsp_popped_ff;
      rsp_pos_in     = rsp_pos_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = tail_ff;
      mem_wr_data    = req_value;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in       = S_HOLD;
               pend_status_in = STATUS_OK;
               unique case (req_kind)
                  KIND_PUSH: begin
                     if (count_ff == FULL_CNT) begin
                        pend_status_in = STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        tail_in   = next_slot(tail_ff);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        pend_status_in = STATUS_EMPTY;
                     end else begin
                        mem_rd_en = 1'b1;
                        state_in  = S_POP;
                     end
                  end
                  KIND_SEARCH: begin
                     key_in = req_value;
                     if (count_ff == '0) begin
                        pend_status_in = STATUS_NOT_FOUND;
                     end else begin
                        mem_rd_en    = 1'b1;
                        scan_addr_in = head_ff;
                        scan_in      = CW'(1);
                        state_in     = S_SEARCH;
                     end
                  end
                  default: begin
                     // Unused operation code: report success, change nothing.
                     pend_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_popped_in = '0;
               rsp_pos_in    = '0;
               state_in      = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_popped_in = mem_rd_data;
               rsp_pos_in    = '0;
               head_in       = next_slot(head_ff);
               count_in      = count_ff - 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SEARCH: begin
            // The read data belongs to the entry at position scan_ff from the head.
            if (hit || (scan_ff == count_ff)) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = hit ? STATUS_OK : STATUS_NOT_FOUND;
                  rsp_popped_in = '0;
                  rsp_pos_in    = hit ? POS_W'(scan_ff) : '0;
                  state_in      = S_IDLE;
               end
            end else begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = next_slot(scan_addr_ff);
               scan_addr_in = next_slot(scan_addr_ff);
               scan_in      = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, pointers and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_addr_ff   <= scan_addr_in;
      scan_ff        <= scan_in;
      key_ff         <= key_in;
      pend_status_ff <= pend_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_popped_ff  <= rsp_popped_in;
      rsp_pos_ff     <= rsp_pos_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_position     = rsp_pos_ff;

   // Occupancy never exceeds the ring size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("occupancy exceeds queue depth");

   // An empty or full ring has head and tail at the same slot.
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> head_ff == tail_ff)
      else $error("head and tail disagree with occupancy");

   // A push into a queue with room adds exactly one entry.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == KIND_PUSH && count_ff != FULL_CNT)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow occupancy");

   // A failed operation carries no popped word and no position.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK)
      |-> (rsp_popped_ff == '0 && rsp_pos_ff == '0))
      else $error("failed transaction carries payload");

endmodule

// ===== rtl/searchable_fifo_queue.sv =====
// Top level of the searchable FIFO queue: storage plus sequencer.
//
// The request channel (req_) carries one operation per transaction: push a
// word at the tail, pop the word at the head, or search for the first entry
// equal to a key, walking from the head. Every request gives exactly one
// response transaction on the rsp_ channel with a status, the popped word
// and the 1-based match position.
// Requests are handled one at a time. A push, a pop or an operation that
// fails at once passes through a hold or pop state that loads the response
// register once it is free; the sequencer then returns to idle, where the
// next request is accepted. A search reads the entry memory one word per
// cycle from the head, examines at most DEPTH entries and loads the
// response on a match or after the last entry examined, and this read
// loop sets the worst-case rate.
// The response sits in an output register: a new request is accepted while
// an earlier response still waits, and the block holds its finished result
// in place when the receiver stalls, until the register frees up.
// Reset empties the queue at once; no clearing pass runs over the memory.
module searchable_fifo_queue #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfq_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [31:0] value
   input  logic [sfq_pkg::KIND_W-1:0]         req_tuser,   // [1:0] kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sfq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [31:0] popped_value, [36:32] position
   output logic [sfq_pkg::STATUS_W-1:0]       rsp_tuser    // [1:0] status
);
   import sfq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_W-1:0]    mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [WORD_W-1:0]    mem_rd_data;
   status_type           rsp_status;
   logic signed [WORD_W-1:0] rsp_popped_value;
   logic [POS_W-1:0]     rsp_position;

   // Sequencer.
   sfq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_kind         (req_tuser),
      .req_value        (req_tdata[WORD_W-1:0]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_position     (rsp_position),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   // Entry memory.
   sfq_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Response packing.
   assign rsp_tdata = {(RSP_TDATA_W - WORD_W - POS_W)'(0), rsp_position, rsp_popped_value};
   assign rsp_tuser = rsp_status;

endmodule
